### src/swfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_pkg
// Shared widths, constants and types of the spectrum bin to waterfall pixel block.
// ----------------------------------------------------------------------------
package swfp_pkg;

	localparam int BIN_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIV_BITS  = 8;

	// stage map: 1 magnitude, 2 square, 3 sum, 4-6 normalize, 7-22 log2 bits,
	// 23 scale multiply, 24 level, 25 clamp, 26 segment, 27 x255,
	// 28-35 divide, 36 output register
	localparam int ST_NORM  = 6;
	localparam int ST_LOG   = ST_NORM + FRAC_BITS;
	localparam int ST_MUL   = ST_LOG + 1;
	localparam int ST_DB    = ST_MUL + 1;
	localparam int ST_CLAMP = ST_DB + 1;
	localparam int ST_SEG   = ST_CLAMP + 1;
	localparam int ST_X255  = ST_SEG + 1;
	localparam int ST_DIV   = ST_X255 + DIV_BITS;
	localparam int N_STAGES = ST_DIV + 1;

	// 160*log10(2) in Q16
	localparam logic [21:0] DB_K = 22'd3156528;
	// rounding half minus the 2^-30 power scale, applied to L*K
	localparam logic signed [46:0] LVL_OFS =
		47'sd2147483648 - 47'sd30 * 47'sd65536 * 47'sd3156528;

	localparam logic signed [12:0] DB_FLOOR   = -13'sd3200;
	localparam logic signed [13:0] MIN_SPAN   = 14'sd16;
	localparam logic signed [12:0] DB_LOW_RST  = -13'sd1920;
	localparam logic signed [12:0] DB_HIGH_RST = -13'sd320;

	localparam logic REG_DB_LOW  = 1'b0;
	localparam logic REG_DB_HIGH = 1'b1;

	typedef enum logic [1:0] {
		SEG_RISE_G,
		SEG_FALL_B,
		SEG_RISE_R,
		SEG_FALL_G
	} seg_t;

endpackage

### src/swfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_if
// Stream channels: FFT bin items in, pixel items out.
// ----------------------------------------------------------------------------
interface swfp_bin_if;
	logic        valid;
	logic        ready;
	logic [31:0] bin_real;
	logic [31:0] bin_imag;
	logic        line_end;

	modport source (output valid, bin_real, bin_imag, line_end, input ready);
	modport sink (input valid, bin_real, bin_imag, line_end, output ready);
endinterface

interface swfp_pix_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] db_level;
	logic [31:0]        pixel_word;
	logic               end_of_line;

	modport source (output valid, db_level, pixel_word, end_of_line, input ready);
	modport sink (input valid, db_level, pixel_word, end_of_line, output ready);
endinterface

### src/swfp_sq_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_sq_step
// One log2 fraction bit: square the Q1.31 mantissa, renormalize, emit bit.
// ----------------------------------------------------------------------------
module swfp_sq_step (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] m_in,
	input  logic [15:0] frac_in,
	output logic [31:0] m_out,
	output logic [15:0] frac_out
);
	logic [63:0] sq;
	logic [32:0] t;

	assign sq = m_in * m_in;
	assign t  = sq[63:31];

	always_ff @(posedge clk) begin
		if (en) begin
			m_out    <= t[32] ? t[32:1] : t[31:0];
			frac_out <= {frac_in[14:0], t[32]};
		end
	end
endmodule

### src/swfp_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_div_step
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module swfp_div_step (
	input  logic        clk,
	input  logic        en,
	input  logic [20:0] rem_in,
	input  logic [19:0] dvs,
	input  logic [7:0]  q_in,
	output logic [20:0] rem_out,
	output logic [7:0]  q_out
);
	logic [21:0] diff;
	logic        ge;

	assign diff = {1'b0, rem_in} - {2'b0, dvs};
	assign ge   = ~diff[21];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? diff[20:0] : rem_in;
			q_out   <= {q_in[6:0], ge};
		end
	end
endmodule

### src/spectrum_bin_to_waterfall_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bin_to_waterfall_pixel
// FFT bin to jet-colored ABGR waterfall pixel with its level in 1/16 dB.
// ----------------------------------------------------------------------------
// Usage:
//   bin_in carries one complex FFT bin per item (bin_real, bin_imag,
//   line_end); pix_out returns one item per bin: db_level (1/16 dB,
//   -3200 for zero power), pixel_word (A 31:24 = 0xFF, B, G, R 7:0) and
//   end_of_line. Items leave in arrival order.
//   Throughput is one item per cycle while pix_out is not stalled. The
//   depth comes from the 16 squaring stages of the log2 unit (one
//   fraction bit each) and the 8 restoring divide stages that scale a
//   color channel by the span.
//   Each stage has its own valid bit and loads when empty or when the
//   stage after it moves, so bubbles close up and bin_in stays ready while
//   any stage is empty. A stalled receiver backs the pipeline up without
//   loss or repeat. The user writes db_low / db_high over the APB port
//   (byte 0 and 4) only while the stream is idle; the block does not
//   enforce this. Reset empties the pipeline and loads -1920 / -320.
// ----------------------------------------------------------------------------
module spectrum_bin_to_waterfall_pixel (
	input  logic        clk,
	input  logic        arst_n,
	swfp_bin_if.sink    bin_in,
	swfp_pix_if.source  pix_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int N  = swfp_pkg::N_STAGES;
	localparam int BW = swfp_pkg::BIN_WIDTH;
	localparam int NF = swfp_pkg::FRAC_BITS;
	localparam int ND = swfp_pkg::DIV_BITS;

	// ---------------- configuration ----------------
	logic signed [12:0] db_low_q, db_high_q;
	logic signed [13:0] span_w;
	logic [12:0]        span;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_low_q  <= swfp_pkg::DB_LOW_RST;
			db_high_q <= swfp_pkg::DB_HIGH_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				swfp_pkg::REG_DB_LOW:  db_low_q  <= pwdata[12:0];
				swfp_pkg::REG_DB_HIGH: db_high_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			swfp_pkg::REG_DB_LOW:  prdata = {{19{db_low_q[12]}}, db_low_q};
			swfp_pkg::REG_DB_HIGH: prdata = {{19{db_high_q[12]}}, db_high_q};
			default:               prdata = '0;
		endcase
	end

	assign span_w = {db_high_q[12], db_high_q} - {db_low_q[12], db_low_q};
	assign span   = (span_w < swfp_pkg::MIN_SPAN) ? 13'd16 : span_w[12:0];

	// ---------------- flow control ----------------
	logic [N:1] vld_q;
	logic [N:1] en;

	assign en[N] = ~vld_q[N] | pix_out.ready;
	for (genvar k = 1; k < N; k++) begin : g_en
		assign en[k] = ~vld_q[k] | en[k+1];
	end
	assign bin_in.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= bin_in.valid;
			for (int k = 2; k <= N; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// line end rides along every stage
	logic eol_s [1:N];
	always_ff @(posedge clk) begin
		if (en[1]) eol_s[1] <= bin_in.line_end;
		for (int k = 2; k <= N; k++) begin
			if (en[k]) eol_s[k] <= eol_s[k-1];
		end
	end

	// ---------------- power ----------------
	logic [BW-1:0] raw_re, raw_im;
	logic [BW-1:0] mag_re_s1, mag_im_s1;
	logic [63:0]   sq_re_s2, sq_im_s2;
	logic [63:0]   p_s3, p_s4, p_s5;

	assign raw_re = bin_in.bin_real[BW-1:0];
	assign raw_im = bin_in.bin_imag[BW-1:0];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mag_re_s1 <= raw_re[BW-1] ? (~raw_re + 1'b1) : raw_re;
			mag_im_s1 <= raw_im[BW-1] ? (~raw_im + 1'b1) : raw_im;
		end
		if (en[2]) begin
			sq_re_s2 <= 64'(mag_re_s1) * 64'(mag_re_s1);
			sq_im_s2 <= 64'(mag_im_s1) * 64'(mag_im_s1);
		end
		if (en[3]) p_s3 <= sq_re_s2 + sq_im_s2;
	end

	// ---------------- leading one, in 16-bit groups ----------------
	logic [3:0] grp_nz;
	logic [3:0] grp_pos [4];
	logic [3:0] grp_nz_s4;
	logic [3:0] grp_pos_s4 [4];
	logic [5:0] e_sel;
	logic       zero_sel;

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			grp_nz[g]  = |p_s3[16*g +: 16];
			grp_pos[g] = '0;
			for (int b = 0; b < 16; b++) begin
				if (p_s3[16*g + b]) grp_pos[g] = 4'(b);
			end
		end
	end

	always_comb begin
		zero_sel = 1'b0;
		priority if (grp_nz_s4[3]) e_sel = {2'd3, grp_pos_s4[3]};
		else if (grp_nz_s4[2])     e_sel = {2'd2, grp_pos_s4[2]};
		else if (grp_nz_s4[1])     e_sel = {2'd1, grp_pos_s4[1]};
		else if (grp_nz_s4[0])     e_sel = {2'd0, grp_pos_s4[0]};
		else begin
			e_sel    = '0;
			zero_sel = 1'b1;
		end
	end

	localparam int ST_LOG_IDX = swfp_pkg::ST_LOG;
	logic [5:0]  e_s  [5:ST_LOG_IDX];
	logic        zero_s [5:swfp_pkg::ST_DB-1];
	logic [31:0] m_s  [0:NF];
	logic [15:0] frac_s [0:NF];
	logic [63:0] shl;

	assign shl = p_s5 << (6'd63 - e_s[5]);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			grp_nz_s4  <= grp_nz;
			grp_pos_s4 <= grp_pos;
			p_s4       <= p_s3;
		end
		if (en[5]) begin
			e_s[5]    <= e_sel;
			zero_s[5] <= zero_sel;
			p_s5      <= p_s4;
		end
		if (en[6]) begin
			m_s[0]    <= shl[63:32];
			frac_s[0] <= '0;
		end
		for (int k = 6; k <= ST_LOG_IDX; k++) begin
			if (en[k]) e_s[k] <= e_s[k-1];
		end
		for (int k = 6; k <= swfp_pkg::ST_DB - 1; k++) begin
			if (en[k]) zero_s[k] <= zero_s[k-1];
		end
	end

	// ---------------- log2 fraction, one bit per stage ----------------
	for (genvar j = 0; j < NF; j++) begin : g_log
		swfp_sq_step u_sq (
			.clk      (clk),
			.en       (en[swfp_pkg::ST_NORM + 1 + j]),
			.m_in     (m_s[j]),
			.frac_in  (frac_s[j]),
			.m_out    (m_s[j+1]),
			.frac_out (frac_s[j+1])
		);
	end

	// ---------------- level in 1/16 dB ----------------
	logic [43:0]        prod_s23;
	logic signed [46:0] lvl_sum;
	logic signed [12:0] db_s [swfp_pkg::ST_DB:N];

	assign lvl_sum = $signed({3'b0, prod_s23}) + swfp_pkg::LVL_OFS;

	always_ff @(posedge clk) begin
		if (en[swfp_pkg::ST_MUL])
			prod_s23 <= 44'({e_s[ST_LOG_IDX], frac_s[NF]}) * 44'(swfp_pkg::DB_K);
		if (en[swfp_pkg::ST_DB])
			db_s[swfp_pkg::ST_DB] <= zero_s[swfp_pkg::ST_DB - 1] ? swfp_pkg::DB_FLOOR
				: lvl_sum[44:32];
		for (int k = swfp_pkg::ST_DB + 1; k <= N; k++) begin
			if (en[k]) db_s[k] <= db_s[k-1];
		end
	end

	// ---------------- colormap ----------------
	logic signed [14:0] dsig;
	logic [12:0]        d_s25;
	logic [14:0]        u, s2x, s3x, s4x;
	swfp_pkg::seg_t     seg_c;
	logic [14:0]        num_c;
	logic [12:0]        num_s26;
	swfp_pkg::seg_t     seg_s [swfp_pkg::ST_SEG:N-1];
	logic               cz_s [swfp_pkg::ST_X255:N-1];
	logic               cf_s [swfp_pkg::ST_X255:N-1];
	logic [20:0]        rem_s [0:ND];
	logic [7:0]         q_s [0:ND];

	assign dsig = {{2{db_s[swfp_pkg::ST_DB][12]}}, db_s[swfp_pkg::ST_DB]}
		- {{2{db_low_q[12]}}, db_low_q};
	assign u    = {d_s25, 2'b00};
	assign s2x  = {1'b0, span, 1'b0};
	assign s3x  = s2x + {2'b0, span};
	assign s4x  = {span, 2'b00};

	always_comb begin
		priority if (u <= {2'b0, span}) begin
			seg_c = swfp_pkg::SEG_RISE_G;
			num_c = u;
		end else if (u <= s2x) begin
			seg_c = swfp_pkg::SEG_FALL_B;
			num_c = s2x - u;
		end else if (u <= s3x) begin
			seg_c = swfp_pkg::SEG_RISE_R;
			num_c = u - s2x;
		end else begin
			seg_c = swfp_pkg::SEG_FALL_G;
			num_c = s4x - u;
		end
	end

	always_ff @(posedge clk) begin
		if (en[swfp_pkg::ST_CLAMP]) begin
			if (dsig < 15'sd0)                        d_s25 <= '0;
			else if (dsig > $signed({2'b0, span}))   d_s25 <= span;
			else                                      d_s25 <= dsig[12:0];
		end
		if (en[swfp_pkg::ST_SEG]) begin
			seg_s[swfp_pkg::ST_SEG] <= seg_c;
			num_s26                 <= num_c[12:0];
		end
		if (en[swfp_pkg::ST_X255]) begin
			cz_s[swfp_pkg::ST_X255] <= (num_s26 == '0);
			cf_s[swfp_pkg::ST_X255] <= (num_s26 >= span);
			rem_s[0]                <= {num_s26, 8'b0} - {8'b0, num_s26};
			q_s[0]                  <= '0;
		end
		for (int k = swfp_pkg::ST_SEG + 1; k <= N - 1; k++) begin
			if (en[k]) seg_s[k] <= seg_s[k-1];
		end
		for (int k = swfp_pkg::ST_X255 + 1; k <= N - 1; k++) begin
			if (en[k]) begin
				cz_s[k] <= cz_s[k-1];
				cf_s[k] <= cf_s[k-1];
			end
		end
	end

	for (genvar j = 0; j < ND; j++) begin : g_div
		logic [19:0] dvs;
		assign dvs = {7'b0, span} << (ND - 1 - j);
		swfp_div_step u_div (
			.clk     (clk),
			.en      (en[swfp_pkg::ST_X255 + 1 + j]),
			.rem_in  (rem_s[j]),
			.dvs     (dvs),
			.q_in    (q_s[j]),
			.rem_out (rem_s[j+1]),
			.q_out   (q_s[j+1])
		);
	end

	// ---------------- pack ----------------
	logic [7:0]  chan;
	logic [31:0] pix_c, pix_s36;
	localparam int SP = N - 1;

	assign chan = cz_s[SP] ? 8'h00 : (cf_s[SP] ? 8'hFF : q_s[ND]);

	always_comb begin
		unique case (seg_s[SP])
			swfp_pkg::SEG_RISE_G: pix_c = {8'hFF, 8'hFF, chan, 8'h00};
			swfp_pkg::SEG_FALL_B: pix_c = {8'hFF, chan, 8'hFF, 8'h00};
			swfp_pkg::SEG_RISE_R: pix_c = {8'hFF, 8'h00, 8'hFF, chan};
			swfp_pkg::SEG_FALL_G: pix_c = {8'hFF, 8'h00, chan, 8'hFF};
			default:              pix_c = {8'hFF, 24'h0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[N]) pix_s36 <= pix_c;
	end

	assign pix_out.valid       = vld_q[N];
	assign pix_out.db_level    = db_s[N];
	assign pix_out.pixel_word  = pix_s36;
	assign pix_out.end_of_line = eol_s[N];
endmodule

### src/swfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_checker
// Port-level checks of the pixel output stream, bound to the top level.
// ----------------------------------------------------------------------------
module swfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [12:0] out_db,
	input logic [31:0]        out_pixel
);
	// a waiting item stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel item dropped while stalled");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_pixel[31:24] == 8'hFF)
		else $error("alpha not opaque");

	// jet always has one saturated channel
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_pixel[23:16] == 8'hFF || out_pixel[15:8] == 8'hFF
			|| out_pixel[7:0] == 8'hFF))
		else $error("no saturated color channel");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_db == -13'sd3200
			|| (out_db >= -13'sd1445 && out_db <= 13'sd1589)))
		else $error("level out of range");
endmodule

bind spectrum_bin_to_waterfall_pixel swfp_checker u_swfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_db    (pix_out.db_level),
	.out_pixel (pix_out.pixel_word)
);
